@@ sv/perspective_point_projector_core_defines.svh @@
// ---------------------------------------------------------------------------
// Perspective point projector: assertion macros
// Clocked concurrent checks with asynchronous active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_POINT_PROJECTOR_CORE_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset
`define PPP_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ppp: assertion failed");
// Check that a condition never holds outside reset
`define PPP_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ppp: forbidden condition");
`else
`define PPP_ASSERT(label, clk, rstn, prop)
`define PPP_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

@@ sv/ppp_pkg.sv @@
// ---------------------------------------------------------------------------
// Perspective point projector package
// Widths, register indexes, types and arithmetic helpers of the core.
// ---------------------------------------------------------------------------
package ppp_pkg;

  // Coordinate format
  localparam int CoordW   = 32;
  localparam int FracBits = 16;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 2 * CoordW;

  // Setup datapath widths
  localparam int VpW   = CoordW + 14;
  localparam int SpanW = VpW + 1;
  localparam int DifW  = CoordW + 1;
  localparam int ProdW = 2 * DifW;
  localparam int HvalW = CoordW + 16;
  localparam int WideW = 70;
  localparam int CntW  = $clog2(ProdW);
  localparam int TenK  = 10000;

  // Item datapath widths
  localparam int CoefW   = 52;
  localparam int CoefLoW = 26;
  localparam int CoefHiW = CoefW - CoefLoW;
  localparam int PhW     = CoefHiW + CoordW;
  localparam int PlW     = CoefLoW + 1 + CoordW;
  localparam int NumW    = 84;
  localparam int DenW    = 36;
  localparam int QW      = CoordW;

  // Entry, four arithmetic stages, divider setup, QW divider steps, output
  localparam int NumStages = QW + 7;

  localparam logic [CoordW-1:0] HorizonReset = CoordW'(400 * (1 << FracBits));
  localparam logic [1:0]        LinesBoth    = 2'b11;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegLeftStart  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegLeftEnd    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegRightStart = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegRightEnd   = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegHorizon    = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegLines      = CfgIdxW'(5);

  typedef enum logic [1:0] {
    KIND_PROJECT  = 2'd0,
    KIND_MIRROR_V = 2'd1,
    KIND_MIRROR_H = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PRE_IDLE,
    PRE_MUL,
    PRE_ABS,
    PRE_DIV,
    PRE_VP,
    PRE_DERIVE
  } pre_state_e;

  // One lane of the pipelined restoring divider
  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [DenW-1:0] dv;
    logic [QW-1:0]   low;
    logic [QW-1:0]   q;
    logic            neg;
    logic            ovf;
  } div_lane_t;

  // Per-item side information carried along the pipeline
  typedef struct packed {
    logic                     proj;
    logic signed [CoordW-1:0] fx;
    logic signed [CoordW-1:0] fy;
    logic                     fp;
  } side_t;

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [WideW-1:0] x);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = (WideW'(1) <<< (CoordW - 1)) - WideW'(1);
    lo = -(WideW'(1) <<< (CoordW - 1));
    if (x > hi) return CoordMax;
    if (x < lo) return CoordMin;
    return x[CoordW-1:0];
  endfunction

  function automatic logic signed [VpW-1:0] sat_vp(input logic signed [WideW-1:0] x);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = (WideW'(1) <<< (VpW - 1)) - WideW'(1);
    lo = -(WideW'(1) <<< (VpW - 1));
    if (x > hi) return hi[VpW-1:0];
    if (x < lo) return lo[VpW-1:0];
    return x[VpW-1:0];
  endfunction

  // One quotient bit: shift in the next numerator bit, subtract if it fits
  function automatic div_lane_t div_step(input div_lane_t a);
    div_lane_t       r;
    logic [DenW:0]   t;
    r = a;
    t = {a.rem, a.low[QW-1]};
    if (t >= {1'b0, a.dv}) begin
      r.rem = DenW'(t - {1'b0, a.dv});
      r.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      r.rem = t[DenW-1:0];
      r.q   = {a.q[QW-2:0], 1'b0};
    end
    r.low = {a.low[QW-2:0], 1'b0};
    return r;
  endfunction

  // Round to nearest (ties away from zero), apply sign, saturate
  function automatic logic signed [CoordW-1:0] div_finish(input div_lane_t a);
    logic                   rnd;
    logic [QW:0]            qr;
    logic signed [QW+1:0]   sq;
    rnd = ({a.rem, 1'b0} >= {1'b0, a.dv});
    qr  = (QW+1)'(a.q) + (QW+1)'(rnd);
    sq  = $signed({1'b0, qr});
    if (a.neg) sq = -sq;
    if (a.ovf) return a.neg ? CoordMin : CoordMax;
    return sat_coord(WideW'(sq));
  endfunction

endpackage

@@ sv/perspective_point_projector_core.sv @@
// ---------------------------------------------------------------------------
// Perspective point projector core
// Two-point perspective floor mapping with mirror operations, pipelined.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         in_valid_i / in_ready_o   kind_i, point_x_i, point_y_i
//  output    out        out_valid_o / out_ready_i out_x_o, out_y_o, passed_through_o
//  config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
//  One request per cycle sustained while the output is not stalled and no setup runs.
//  The pipeline depth is set mostly by the 32-step pipelined divider of the perspective divide.
//  After reset and after each config write a setup sequencer derives the
//  vanishing points with a serial divider, holding in_ready_o low.
//  A stalled output parks in a skid register while the pipeline freezes.
// ---------------------------------------------------------------------------
`include "perspective_point_projector_core_defines.svh"

module perspective_point_projector_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        kind_i,
  input  logic signed [ppp_pkg::CoordW-1:0] point_x_i,
  input  logic signed [ppp_pkg::CoordW-1:0] point_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ppp_pkg::CoordW-1:0] out_x_o,
  output logic signed [ppp_pkg::CoordW-1:0] out_y_o,
  output logic                              passed_through_o,
  input  logic                              cfg_we_i,
  input  logic [ppp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ppp_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import ppp_pkg::*;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [CfgDataW-1:0]      line_q [4];
  logic signed [CoordW-1:0] horizon_q;
  logic [1:0]               lines_q;
  logic                     pending_q, pending_d;

  // Write the register that the index selects
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q[0] <= '0;
      line_q[1] <= '0;
      line_q[2] <= '0;
      line_q[3] <= '0;
      horizon_q <= HorizonReset;
      lines_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegLeftStart:  line_q[0] <= cfg_wdata_i;
        RegLeftEnd:    line_q[1] <= cfg_wdata_i;
        RegRightStart: line_q[2] <= cfg_wdata_i;
        RegRightEnd:   line_q[3] <= cfg_wdata_i;
        RegHorizon:    horizon_q <= cfg_wdata_i[CoordW-1:0];
        RegLines:      lines_q   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Setup sequencer: vanishing points and projection coefficients
  // -------------------------------------------------------------------------
  pre_state_e               pre_state_q, pre_state_d;
  logic                     sel_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [HvalW-1:0]  hval_q;
  logic                     dy_zero_q;
  logic                     vneg_q;
  logic [ProdW-1:0]         num_q;
  logic [DifW-1:0]          vrem_q;
  logic [DifW-1:0]          vdv_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [VpW-1:0]    vp_q [2];
  logic signed [SpanW-1:0]  c_q;
  logic signed [CoefW-1:0]  ax_q, bx_q, ay_q;
  logic signed [WideW-1:0]  kx_q, ky_q;

  logic [CfgDataW-1:0]      ls, le;
  logic signed [CoordW-1:0] x1, y1, x2, y2;
  logic signed [DifW-1:0]   dx, dy, hy;
  logic [DifW:0]            vt;
  logic                     vge;

  // Pick the handles of the line being worked on
  always_comb begin
    ls  = sel_q ? line_q[2] : line_q[0];
    le  = sel_q ? line_q[3] : line_q[1];
    x1  = ls[CfgDataW-1:CoordW];
    y1  = ls[CoordW-1:0];
    x2  = le[CfgDataW-1:CoordW];
    y2  = le[CoordW-1:0];
    dx  = DifW'(x2) - DifW'(x1);
    dy  = DifW'(y2) - DifW'(y1);
    hy  = DifW'(horizon_q) - DifW'(y1);
    vt  = {vrem_q, num_q[ProdW-1]};
    vge = (vt >= {1'b0, vdv_q});
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_state_q <= PRE_IDLE;
      pending_q   <= 1'b1;
    end else begin
      pre_state_q <= pre_state_d;
      pending_q   <= pending_d;
    end
  end

  // Advance the sequencer
  always_comb begin
    pre_state_d = pre_state_q;
    pending_d   = cfg_we_i || (pending_q && (pre_state_q != PRE_IDLE));
    unique case (pre_state_q)
      PRE_IDLE:   if (pending_q) pre_state_d = PRE_MUL;
      PRE_MUL:    pre_state_d = (dy == '0) ? PRE_VP : PRE_ABS;
      PRE_ABS:    pre_state_d = PRE_DIV;
      PRE_DIV:    if (cnt_q == CntW'(ProdW - 1)) pre_state_d = PRE_VP;
      PRE_VP:     pre_state_d = sel_q ? PRE_DERIVE : PRE_MUL;
      PRE_DERIVE: pre_state_d = PRE_IDLE;
      default:    pre_state_d = PRE_IDLE;
    endcase
  end

  // Line select and iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (pre_state_q == PRE_IDLE) sel_q <= 1'b0;
      else if (pre_state_q == PRE_VP) sel_q <= 1'b1;
      if (pre_state_q == PRE_ABS) cnt_q <= '0;
      else if (pre_state_q == PRE_DIV) cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Setup datapath
  always_ff @(posedge clk_i) begin
    logic signed [SpanW-1:0]  c_w, diff_w, s_w;
    logic                     rnd_w;
    logic [ProdW:0]           qr_w;
    logic signed [ProdW+1:0]  sq_w;
    logic signed [WideW-1:0]  sum_w;
    logic signed [WideW-1:0]  c6_w, s3_w, h3_w;
    unique case (pre_state_q)
      PRE_MUL: begin
        prod_q    <= ProdW'(hy) * ProdW'(dx);
        hval_q    <= HvalW'(x1) + HvalW'(dx) * HvalW'(TenK);
        dy_zero_q <= (dy == '0);
        vneg_q    <= hy[DifW-1] ^ dx[DifW-1] ^ dy[DifW-1];
        vdv_q     <= dy[DifW-1] ? $unsigned(-dy) : $unsigned(dy);
      end
      PRE_ABS: begin
        num_q  <= prod_q[ProdW-1] ? $unsigned(-prod_q) : $unsigned(prod_q);
        vrem_q <= '0;
      end
      PRE_DIV: begin
        vrem_q <= vge ? DifW'(vt - {1'b0, vdv_q}) : vt[DifW-1:0];
        num_q  <= {num_q[ProdW-2:0], vge};
      end
      PRE_VP: begin
        rnd_w = ({vrem_q, 1'b0} >= {1'b0, vdv_q});
        qr_w  = (ProdW+1)'(num_q) + (ProdW+1)'(rnd_w);
        sq_w  = $signed({1'b0, qr_w});
        if (vneg_q) sq_w = -sq_w;
        sum_w = WideW'(sq_w) + WideW'(x1);
        vp_q[sel_q] <= dy_zero_q ? sat_vp(WideW'(hval_q)) : sat_vp(sum_w);
      end
      PRE_DERIVE: begin
        c_w    = SpanW'(vp_q[0]) + SpanW'(vp_q[1]);
        diff_w = SpanW'(vp_q[1]) - SpanW'(vp_q[0]);
        s_w    = diff_w[SpanW-1] ? -diff_w : diff_w;
        if (s_w < (SpanW'(1) <<< FracBits)) s_w = SpanW'(1) <<< FracBits;
        c6_w   = (WideW'(c_w) <<< 2) + (WideW'(c_w) <<< 1);
        s3_w   = (WideW'(s_w) <<< 1) + WideW'(s_w);
        h3_w   = (WideW'(horizon_q) <<< 1) + WideW'(horizon_q);
        c_q    <= c_w;
        ax_q   <= (CoefW'(s_w) <<< 2) + (CoefW'(s_w) <<< 1);
        bx_q   <= CoefW'(c_w) <<< 2;
        ay_q   <= CoefW'(s_w) + (CoefW'(horizon_q) <<< 1);
        kx_q   <= (c6_w - s3_w) <<< FracBits;
        ky_q   <= h3_w <<< FracBits;
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // Item pipeline
  // -------------------------------------------------------------------------
  logic                   adv;
  logic                   accept;
  logic [NumStages-1:0]   vld_q;
  side_t                  side_q [NumStages-1];
  side_t                  side_in;
  logic signed [DenW-1:0] d_in;
  logic signed [WideW-1:0] mx_w, my_w;
  logic                   skid_q;
  logic signed [CoordW-1:0] skid_x_q, skid_y_q, res_x_q, res_y_q;
  logic                   skid_p_q, res_p_q;

  assign adv        = !skid_q;
  assign in_ready_o = adv && (pre_state_q == PRE_IDLE) && !pending_q;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the request and resolve mirror and pass-through results
  always_comb begin
    d_in = (DenW'(3) <<< FracBits) + (DenW'(point_y_i) <<< 1);
    mx_w = WideW'(c_q) - WideW'(point_x_i);
    my_w = (WideW'(horizon_q) <<< 1) - WideW'(point_y_i);
    side_in.proj = 1'b0;
    side_in.fx   = point_x_i;
    side_in.fy   = point_y_i;
    side_in.fp   = 1'b1;
    if (lines_q == LinesBoth) begin
      unique case (kind_e'(kind_i))
        KIND_PROJECT: begin
          if (d_in != '0) begin
            side_in.proj = 1'b1;
            side_in.fp   = 1'b0;
          end
        end
        KIND_MIRROR_V: begin
          side_in.fx = sat_coord(mx_w);
          side_in.fp = 1'b0;
        end
        KIND_MIRROR_H: begin
          side_in.fy = sat_coord(my_w);
          side_in.fp = 1'b0;
        end
        KIND_UNUSED: ;
      endcase
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NumStages-2:0], accept};
  end

  // Shift side information
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < NumStages - 1; k++) side_q[k] <= side_q[k-1];
    end
  end

  logic signed [CoordW-1:0] s1_u_q, s1_v_q;
  logic signed [DenW-1:0]   s1_d_q, s2_d_q, s3_d_q, s4_dx_q, s4_dy_q;
  logic signed [PhW-1:0]    s2_xh_q, s2_ch_q, s2_yh_q;
  logic signed [PlW-1:0]    s2_xl_q, s2_cl_q, s2_yl_q;
  logic signed [NumW-1:0]   s3_px_q, s3_pc_q, s3_py_q, s4_nx_q, s4_ny_q;
  logic [NumW-1:0]          s5_mx_q, s5_my_q;
  logic [DenW-1:0]          s5_dvx_q, s5_dvy_q;
  logic                     s5_negx_q, s5_negy_q;
  div_lane_t                divx_q [QW+1];
  div_lane_t                divy_q [QW+1];

  // Capture, multiply, sum and normalize
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Capture the point and the floor divisor
      s1_u_q <= point_x_i;
      s1_v_q <= point_y_i;
      s1_d_q <= d_in;
      // Split coefficient products into two partials each
      s2_xh_q <= PhW'($signed(ax_q[CoefW-1:CoefLoW])) * PhW'(s1_u_q);
      s2_xl_q <= PlW'($signed({1'b0, ax_q[CoefLoW-1:0]})) * PlW'(s1_u_q);
      s2_ch_q <= PhW'($signed(bx_q[CoefW-1:CoefLoW])) * PhW'(s1_v_q);
      s2_cl_q <= PlW'($signed({1'b0, bx_q[CoefLoW-1:0]})) * PlW'(s1_v_q);
      s2_yh_q <= PhW'($signed(ay_q[CoefW-1:CoefLoW])) * PhW'(s1_v_q);
      s2_yl_q <= PlW'($signed({1'b0, ay_q[CoefLoW-1:0]})) * PlW'(s1_v_q);
      s2_d_q  <= s1_d_q;
      // Join partials
      s3_px_q <= (NumW'(s2_xh_q) <<< CoefLoW) + NumW'(s2_xl_q);
      s3_pc_q <= (NumW'(s2_ch_q) <<< CoefLoW) + NumW'(s2_cl_q);
      s3_py_q <= (NumW'(s2_yh_q) <<< CoefLoW) + NumW'(s2_yl_q);
      s3_d_q  <= s2_d_q;
      // Form numerators and divisors
      s4_nx_q <= s3_px_q + s3_pc_q + NumW'(kx_q);
      s4_ny_q <= s3_py_q + NumW'(ky_q);
      s4_dx_q <= s3_d_q <<< 2;
      s4_dy_q <= s3_d_q;
      // Take magnitudes and quotient signs
      s5_mx_q   <= s4_nx_q[NumW-1] ? $unsigned(-s4_nx_q) : $unsigned(s4_nx_q);
      s5_my_q   <= s4_ny_q[NumW-1] ? $unsigned(-s4_ny_q) : $unsigned(s4_ny_q);
      s5_dvx_q  <= s4_dx_q[DenW-1] ? $unsigned(-s4_dx_q) : $unsigned(s4_dx_q);
      s5_dvy_q  <= s4_dy_q[DenW-1] ? $unsigned(-s4_dy_q) : $unsigned(s4_dy_q);
      s5_negx_q <= s4_nx_q[NumW-1] ^ s4_dx_q[DenW-1];
      s5_negy_q <= s4_ny_q[NumW-1] ^ s4_dy_q[DenW-1];
      // Detect quotient overflow and load the dividers
      divx_q[0].ovf <= (s5_mx_q[NumW-1:QW] >= (NumW-QW)'(s5_dvx_q));
      divx_q[0].rem <= s5_mx_q[QW+DenW-1:QW];
      divx_q[0].low <= s5_mx_q[QW-1:0];
      divx_q[0].q   <= '0;
      divx_q[0].dv  <= s5_dvx_q;
      divx_q[0].neg <= s5_negx_q;
      divy_q[0].ovf <= (s5_my_q[NumW-1:QW] >= (NumW-QW)'(s5_dvy_q));
      divy_q[0].rem <= s5_my_q[QW+DenW-1:QW];
      divy_q[0].low <= s5_my_q[QW-1:0];
      divy_q[0].q   <= '0;
      divy_q[0].dv  <= s5_dvy_q;
      divy_q[0].neg <= s5_negy_q;
    end
  end

  // Divider steps, one quotient bit per stage
  for (genvar g = 1; g <= QW; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        divx_q[g] <= div_step(divx_q[g-1]);
        divy_q[g] <= div_step(divy_q[g-1]);
      end
    end
  end

  // Round, saturate, or take the resolved result
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_x_q <= side_q[NumStages-2].proj ? div_finish(divx_q[QW]) : side_q[NumStages-2].fx;
      res_y_q <= side_q[NumStages-2].proj ? div_finish(divy_q[QW]) : side_q[NumStages-2].fy;
      res_p_q <= side_q[NumStages-2].proj ? 1'b0 : side_q[NumStages-2].fp;
    end
  end

  // Park a refused result in the skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else if (skid_q) begin
      if (out_ready_i) skid_q <= 1'b0;
    end else if (vld_q[NumStages-1] && !out_ready_i) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q) begin
      skid_x_q <= res_x_q;
      skid_y_q <= res_y_q;
      skid_p_q <= res_p_q;
    end
  end

  // Present the oldest result
  assign out_valid_o      = skid_q || vld_q[NumStages-1];
  assign out_x_o          = skid_q ? skid_x_q : res_x_q;
  assign out_y_o          = skid_q ? skid_y_q : res_y_q;
  assign passed_through_o = skid_q ? skid_p_q : res_p_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `PPP_ASSERT(a_skid_holds, clk_i, rst_ni, skid_q && !out_ready_i |=> skid_q)
  `PPP_ASSERT(a_skid_drains, clk_i, rst_ni, skid_q && out_ready_i |=> !skid_q)
  `PPP_ASSERT(a_pipe_frozen, clk_i, rst_ni, skid_q |=> $stable(vld_q))
  `PPP_ASSERT_NEVER(a_no_accept_in_setup, clk_i, rst_ni, accept && (pre_state_q != PRE_IDLE))

endmodule
